@@ hdl/frac_pkg.sv @@
package frac_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);
  localparam int PC_W       = 4;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [PC_W-1:0]       pc_t;

  // Datapath operation of one microcode step
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_AB,
    OP_SWAP,
    OP_DIV_N,
    OP_DIV_D,
    OP_EMIT,
    OP_EMIT_UNDEF
  } op_t;

  // Branch condition taken when the step completes
  typedef enum logic [1:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_B_ZERO,
    COND_A_ZERO
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  // Program addresses
  localparam pc_t PC_LOAD   = PC_W'(0);
  localparam pc_t PC_TEST_B = PC_W'(1);
  localparam pc_t PC_DIV_AB = PC_W'(2);
  localparam pc_t PC_SWAP   = PC_W'(3);
  localparam pc_t PC_TEST_G = PC_W'(4);
  localparam pc_t PC_DIV_N  = PC_W'(5);
  localparam pc_t PC_DIV_D  = PC_W'(6);
  localparam pc_t PC_EMIT   = PC_W'(7);
  localparam pc_t PC_UNDEF  = PC_W'(8);

  // Divider handshake between sequencer and divider
  typedef struct packed {
    logic  start;
    data_t dividend;
    data_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    data_t quotient;
    data_t remainder;
  } div_rsp_t;

  // Control store: Euclid loop, then two scaling divisions
  function automatic ucode_t ucode_rom(pc_t pc);
    ucode_t w;
    unique case (pc)
      PC_LOAD:   w = '{OP_LOAD,       COND_NEXT,   PC_LOAD};
      PC_TEST_B: w = '{OP_NOP,        COND_B_ZERO, PC_TEST_G};
      PC_DIV_AB: w = '{OP_DIV_AB,     COND_NEXT,   PC_LOAD};
      PC_SWAP:   w = '{OP_SWAP,       COND_ALWAYS, PC_TEST_B};
      PC_TEST_G: w = '{OP_NOP,        COND_A_ZERO, PC_UNDEF};
      PC_DIV_N:  w = '{OP_DIV_N,      COND_NEXT,   PC_LOAD};
      PC_DIV_D:  w = '{OP_DIV_D,      COND_NEXT,   PC_LOAD};
      PC_EMIT:   w = '{OP_EMIT,       COND_ALWAYS, PC_LOAD};
      PC_UNDEF:  w = '{OP_EMIT_UNDEF, COND_ALWAYS, PC_LOAD};
      default:   w = '{OP_NOP,        COND_ALWAYS, PC_LOAD};
    endcase
    return w;
  endfunction

  // Unsigned magnitude of a two's complement word (MIN maps to 2^(W-1))
  function automatic data_t magnitude(data_t v);
    return v[DATA_WIDTH-1] ? data_t'(~v + data_t'(1)) : v;
  endfunction

  // Reapply the original sign to a magnitude, modulo 2^W
  function automatic data_t apply_sign(data_t q, logic neg);
    return neg ? data_t'(~q + data_t'(1)) : q;
  endfunction

endpackage

@@ hdl/frac_ifs.sv @@
interface frac_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [frac_pkg::DATA_WIDTH-1:0] numerator;
  logic signed [frac_pkg::DATA_WIDTH-1:0] denominator;

  modport source (output valid, numerator, denominator, input ready);
  modport sink   (input valid, numerator, denominator, output ready);
endinterface

interface frac_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [frac_pkg::DATA_WIDTH-1:0] reduced_numerator;
  logic signed [frac_pkg::DATA_WIDTH-1:0] reduced_denominator;
  logic                                   undefined;

  modport source (output valid, reduced_numerator, reduced_denominator, undefined,
                  input ready);
  modport sink   (input valid, reduced_numerator, reduced_denominator, undefined,
                  output ready);
endinterface

@@ hdl/frac_divider.sv @@
// Restoring divider, one quotient bit per cycle
module frac_divider (
  input  logic               clk,
  input  logic               rst,
  input  frac_pkg::div_req_t req,
  output frac_pkg::div_rsp_t rsp
);

  logic             busy;
  logic             done;
  frac_pkg::cnt_t   cnt;
  frac_pkg::data_t  rem;
  frac_pkg::data_t  quo;
  frac_pkg::data_t  dvsr;

  logic [frac_pkg::DATA_WIDTH:0] shifted;
  logic [frac_pkg::DATA_WIDTH:0] diff;

  // Trial subtraction of the divisor from the shifted partial remainder
  assign shifted = {rem, quo[frac_pkg::DATA_WIDTH-1]};
  assign diff    = shifted - {1'b0, dvsr};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= frac_pkg::CNT_W'(frac_pkg::DATA_WIDTH - 1);
      end else if (busy) begin
        cnt <= cnt - frac_pkg::CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      quo  <= req.dividend;
      dvsr <= req.divisor;
    end else if (busy) begin
      if (!diff[frac_pkg::DATA_WIDTH]) begin
        rem <= diff[frac_pkg::DATA_WIDTH-1:0];
        quo <= {quo[frac_pkg::DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem <= shifted[frac_pkg::DATA_WIDTH-1:0];
        quo <= {quo[frac_pkg::DATA_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

@@ hdl/fraction_reducer_unit.sv @@
// One result word per operand word, after k Euclid remainder steps and two scaling
// divisions (k is 0 to 45 for 32-bit magnitudes); each division runs on the shared
// one-bit-per-cycle divider, which sets the rate. One word in flight; the next operand
// word is taken while the previous result word still waits at the output register.
// Reset (rst, synchronous): sequencer returns to the load step, output word invalid.
module fraction_reducer_unit (
  input logic        clk,
  input logic        rst,
  frac_in_if.sink    operands,
  frac_out_if.source result
);

  frac_pkg::pc_t      pc;
  frac_pkg::ucode_t   uw;
  logic               step_done;
  logic               cond_true;
  logic               div_started;
  logic               is_div;
  frac_pkg::div_req_t div_req;
  frac_pkg::div_rsp_t div_rsp;

  // Datapath registers
  frac_pkg::data_t a;
  frac_pkg::data_t b;
  frac_pkg::data_t mag_n;
  frac_pkg::data_t mag_d;
  frac_pkg::data_t quo_n;
  frac_pkg::data_t quo_d;
  logic            neg_n;
  logic            neg_d;

  assign uw = frac_pkg::ucode_rom(pc);

  assign operands.ready = (uw.op == frac_pkg::OP_LOAD);

  assign is_div = (uw.op == frac_pkg::OP_DIV_AB) || (uw.op == frac_pkg::OP_DIV_N) ||
                  (uw.op == frac_pkg::OP_DIV_D);

  // Branch condition
  always_comb begin
    unique case (uw.cond)
      frac_pkg::COND_NEXT:   cond_true = 1'b0;
      frac_pkg::COND_ALWAYS: cond_true = 1'b1;
      frac_pkg::COND_B_ZERO: cond_true = (b == '0);
      frac_pkg::COND_A_ZERO: cond_true = (a == '0);
      default:               cond_true = 1'b0;
    endcase
  end

  // Step completion: wait on input word, divider, or output register
  always_comb begin
    unique case (uw.op) inside
      frac_pkg::OP_LOAD:                       step_done = operands.valid;
      frac_pkg::OP_DIV_AB, frac_pkg::OP_DIV_N,
      frac_pkg::OP_DIV_D:                      step_done = div_rsp.done;
      frac_pkg::OP_EMIT, frac_pkg::OP_EMIT_UNDEF:
                                               step_done = !result.valid || result.ready;
      default:                                 step_done = 1'b1;
    endcase
  end

  // Divider operand select
  always_comb begin
    div_req.start = is_div && !div_started;
    case (uw.op)
      frac_pkg::OP_DIV_AB: begin
        div_req.dividend = a;
        div_req.divisor  = b;
      end
      frac_pkg::OP_DIV_N: begin
        div_req.dividend = mag_n;
        div_req.divisor  = a;
      end
      default: begin
        div_req.dividend = mag_d;
        div_req.divisor  = a;
      end
    endcase
  end

  frac_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= frac_pkg::PC_LOAD;
      div_started  <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (step_done) begin
        pc          <= cond_true ? uw.target : pc + frac_pkg::PC_W'(1);
        div_started <= 1'b0;
      end else if (div_req.start) begin
        div_started <= 1'b1;
      end
      // set on emit, cleared once the word is taken
      if (step_done &&
          ((uw.op == frac_pkg::OP_EMIT) || (uw.op == frac_pkg::OP_EMIT_UNDEF))) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // Datapath, one operation per completed step
  always_ff @(posedge clk) begin
    if (step_done) begin
      case (uw.op)
        frac_pkg::OP_LOAD: begin
          a     <= frac_pkg::magnitude(frac_pkg::data_t'(operands.numerator));
          b     <= frac_pkg::magnitude(frac_pkg::data_t'(operands.denominator));
          mag_n <= frac_pkg::magnitude(frac_pkg::data_t'(operands.numerator));
          mag_d <= frac_pkg::magnitude(frac_pkg::data_t'(operands.denominator));
          neg_n <= operands.numerator[frac_pkg::DATA_WIDTH-1];
          neg_d <= operands.denominator[frac_pkg::DATA_WIDTH-1];
        end
        frac_pkg::OP_SWAP: begin
          a <= b;
          b <= div_rsp.remainder;
        end
        frac_pkg::OP_DIV_N: quo_n <= div_rsp.quotient;
        frac_pkg::OP_DIV_D: quo_d <= div_rsp.quotient;
        frac_pkg::OP_EMIT: begin
          result.reduced_numerator   <= signed'(frac_pkg::apply_sign(quo_n, neg_n));
          result.reduced_denominator <= signed'(frac_pkg::apply_sign(quo_d, neg_d));
          result.undefined           <= 1'b0;
        end
        frac_pkg::OP_EMIT_UNDEF: begin
          result.reduced_numerator   <= '0;
          result.reduced_denominator <= '0;
          result.undefined           <= 1'b1;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Divider only finishes while the sequencer waits on it
  assert property (@(posedge clk) disable iff (rst) div_rsp.done |-> is_div)
    else $error("divider done outside a divide step");

  // An accepted word starts the Euclid loop
  assert property (@(posedge clk) disable iff (rst)
                   operands.valid && operands.ready |=> pc == frac_pkg::PC_TEST_B)
    else $error("load step did not advance to the gcd loop");

  // Undefined words are 0/0; defined words are never 0/0
  assert property (@(posedge clk) disable iff (rst)
                   result.valid |-> (result.undefined ==
                   ((result.reduced_numerator == '0) && (result.reduced_denominator == '0))))
    else $error("undefined flag disagrees with result word");
`endif

endmodule

@@ tb/sv/fraction_reducer_checker.sv @@
`timescale 1ns / 100ps

module fraction_reducer_checker (
  input  logic clk,
  input  logic rst,
  frac_in_if   operands,
  frac_out_if  result,
  output int   mismatches,
  output int   pending,
  output int   checked,
  output int   undef_seen,
  output int   longest_chain
);
  import frac_pkg::*;

  typedef struct packed {
    data_t num;
    data_t den;
    logic  undef;
  } reduced_t;

  // expected result words, oldest first
  reduced_t reduced_fifo[$];

  int fail_cnt  = 0;
  int n_pending = 0;
  int n_checked = 0;
  int n_undef   = 0;
  int max_chain = 0;

  assign mismatches    = fail_cnt;
  assign pending       = n_pending;
  assign checked       = n_checked;
  assign undef_seen    = n_undef;
  assign longest_chain = max_chain;

  // lowest terms of n/d; each part keeps its own sign, 0/0 flags undefined
  function automatic reduced_t reduce_fraction(input data_t n, input data_t d,
                                               output int chain);
    data_t mag_n, mag_d, a, b, rem;
    reduced_t w;
    mag_n = n[DATA_WIDTH-1] ? data_t'(-n) : n;  // MIN stays 2^(W-1) unsigned
    mag_d = d[DATA_WIDTH-1] ? data_t'(-d) : d;
    a     = mag_n;
    b     = mag_d;
    chain = 0;
    while (b != '0) begin
      rem   = a % b;
      a     = b;
      b     = rem;
      chain = chain + 1;
    end
    if (a == '0) begin
      w.num   = '0;
      w.den   = '0;
      w.undef = 1'b1;
    end else begin
      w.num   = n[DATA_WIDTH-1] ? data_t'(-(mag_n / a)) : mag_n / a;
      w.den   = d[DATA_WIDTH-1] ? data_t'(-(mag_d / a)) : mag_d / a;
      w.undef = 1'b0;
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what, input data_t got, input data_t want);
    fail_cnt++;
    if (fail_cnt <= 40) begin
      $display("%0t: mismatch on %s: got %0d, expected %0d",
               $time, what, $signed(got), $signed(want));
    end
  endtask

  // compare the accepted result word first, then queue the new operand word
  always @(posedge clk) begin
    reduced_t got, want;
    int       chain;
    if (!rst) begin
      if (result.valid && result.ready) begin
        got.num   = result.reduced_numerator;
        got.den   = result.reduced_denominator;
        got.undef = result.undefined;
        if (reduced_fifo.size() == 0) begin
          report_mismatch("result word with none expected", got.num, '0);
        end else begin
          want = reduced_fifo.pop_front();
          if (got.num !== want.num) begin
            report_mismatch("reduced_numerator", got.num, want.num);
          end
          if (got.den !== want.den) begin
            report_mismatch("reduced_denominator", got.den, want.den);
          end
          if (got.undef !== want.undef) begin
            report_mismatch("undefined", data_t'(got.undef), data_t'(want.undef));
          end
          n_checked++;
          if (want.undef) begin
            n_undef++;
          end
        end
      end
      if (operands.valid && operands.ready) begin
        want = reduce_fraction(operands.numerator, operands.denominator, chain);
        if (chain > max_chain) begin
          max_chain = chain;
        end
        reduced_fifo.push_back(want);
      end
      n_pending = reduced_fifo.size();
    end
  end

endmodule

@@ tb/sv/fraction_reducer_unit_tb.sv @@
`timescale 1ns / 100ps

module fraction_reducer_unit_tb;
  import frac_pkg::*;

  localparam int    RANDOM_WORDS = 1180;
  localparam int    TAIL_CYCLES  = 2000;  // longer than one full Euclid chain
  localparam int    TIMEOUT_NS   = 200_000_000;
  localparam data_t MAX_POS      = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t MIN_NEG      = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam data_t FIB_46       = data_t'(1836311903);
  localparam data_t FIB_45       = data_t'(1134903170);

  logic clk = 1'b0;
  logic rst;

  int mismatches, pending, checked, undef_seen, longest_chain;
  int burst_left = 0;

  frac_in_if  operands_if ();
  frac_out_if result_if ();

  fraction_reducer_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .operands (operands_if),
    .result   (result_if)
  );

  fraction_reducer_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .operands      (operands_if),
    .result        (result_if),
    .mismatches    (mismatches),
    .pending       (pending),
    .checked       (checked),
    .undef_seen    (undef_seen),
    .longest_chain (longest_chain)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic data_t with_sign(input data_t m, input bit neg);
    return neg ? data_t'(-m) : m;
  endfunction

  // one operand word; bursts of random length with random gaps between them
  task automatic send_word(input data_t n, input data_t d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1200) : $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk);
        operands_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    operands_if.valid       <= 1'b1;
    operands_if.numerator   <= n;
    operands_if.denominator <= d;
    @(posedge clk);
    while (!operands_if.ready) @(posedge clk);
  endtask

  // receiver: switches between always ready, coin flips and long stalls
  initial begin
    int   mode, mode_left, hold;
    logic level;
    mode      = 0;
    mode_left = 0;
    hold      = 0;
    level     = 1'b1;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 3000);
      end
      mode_left--;
      case (mode)
        0: begin
          result_if.ready <= 1'b1;
        end
        1: begin
          result_if.ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          if (hold == 0) begin
            hold  = level ? $urandom_range(1, 300) : $urandom_range(1, 20);
            level = ~level;
          end
          hold--;
          result_if.ready <= level;
        end
      endcase
    end
  end

  // stimulus
  initial begin
    data_t fa, fb, ft, g;
    int    depth;
    rst                     = 1'b1;
    operands_if.valid       = 1'b0;
    operands_if.numerator   = '0;
    operands_if.denominator = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed: zeros, signs, extremes, most negative value, longest chain
    send_word('0, '0);
    send_word('0, data_t'(5));
    send_word(data_t'(5), '0);
    send_word(with_sign(data_t'(5), 1'b1), '0);
    send_word('0, with_sign(data_t'(7), 1'b1));
    send_word(data_t'(4), with_sign(data_t'(6), 1'b1));
    send_word(with_sign(data_t'(4), 1'b1), data_t'(6));
    send_word(with_sign(data_t'(4), 1'b1), with_sign(data_t'(6), 1'b1));
    send_word(data_t'(12), data_t'(18));
    send_word(data_t'(1), data_t'(1));
    send_word(with_sign(data_t'(1), 1'b1), with_sign(data_t'(1), 1'b1));
    send_word(data_t'(7), data_t'(13));
    send_word(MAX_POS, MAX_POS);
    send_word(MAX_POS, data_t'(1));
    send_word(data_t'(1), MAX_POS);
    send_word(MAX_POS, with_sign(MAX_POS, 1'b1));
    send_word(with_sign(MAX_POS, 1'b1), '0);
    send_word(MIN_NEG, data_t'(1));
    send_word(MIN_NEG, '0);
    send_word(MIN_NEG, MIN_NEG);
    send_word(MIN_NEG, with_sign(data_t'(1), 1'b1));
    send_word('0, MIN_NEG);
    send_word(MIN_NEG, data_t'(6));
    send_word(FIB_46, FIB_45);
    send_word(with_sign(FIB_45, 1'b1), FIB_46);

    // random part
    repeat (RANDOM_WORDS) begin
      case ($urandom_range(0, 99)) inside
        [0:39]: begin
          send_word(data_t'($urandom), data_t'($urandom));
        end
        [40:64]: begin
          // shared factor so the scaling divisions do real work
          g = $urandom_range(1, 1 << 15);
          send_word(with_sign(g * $urandom_range(0, 1 << 15), 1'($urandom)),
                    with_sign(g * $urandom_range(0, 1 << 15), 1'($urandom)));
        end
        [65:74]: begin
          send_word(with_sign(data_t'($urandom_range(0, 20)), 1'($urandom)),
                    with_sign(data_t'($urandom_range(0, 20)), 1'($urandom)));
        end
        [75:84]: begin
          // zero parts and extreme magnitudes
          case ($urandom_range(0, 4))
            0: send_word('0, data_t'($urandom));
            1: send_word(data_t'($urandom), '0);
            2: send_word('0, '0);
            3: send_word(MIN_NEG, data_t'($urandom));
            default: send_word(with_sign(MAX_POS, 1'($urandom)), data_t'($urandom));
          endcase
        end
        default: begin
          // consecutive Fibonacci terms give long Euclid chains
          depth = $urandom_range(10, 45);
          fa    = data_t'(1);
          fb    = data_t'(1);
          repeat (depth) begin
            ft = fa + fb;
            fa = fb;
            fb = ft;
          end
          if ($urandom_range(0, 1)) begin
            send_word(with_sign(fb, 1'($urandom)), with_sign(fa, 1'($urandom)));
          end else begin
            send_word(with_sign(fa, 1'($urandom)), with_sign(fb, 1'($urandom)));
          end
        end
      endcase
    end

    @(negedge clk);
    operands_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("checked %0d result words, %0d of them 0/0 (undefined)", checked, undef_seen);
    $display("longest Euclid chain seen: %0d remainder steps", longest_chain);
    if (mismatches == 0) begin
      $display("fraction_reducer_unit_tb: PASS");
    end else begin
      $display("fraction_reducer_unit_tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("timeout: %0d result words still outstanding", pending);
    $display("fraction_reducer_unit_tb: FAIL");
    $finish;
  end

endmodule

@@ files.f @@
hdl/frac_pkg.sv
hdl/frac_ifs.sv
hdl/frac_divider.sv
hdl/fraction_reducer_unit.sv
tb/sv/fraction_reducer_checker.sv
tb/sv/fraction_reducer_unit_tb.sv
